// File: rtl/knd_pkg.sv
package knd_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_W = 24;
  localparam int DAY_W = 16;
  localparam int SCORE_W = 8;
  localparam int FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_QUERY  = 2'd1,
    FN_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DAY_W-1:0]   day;
    logic [SCORE_W-1:0] score;
  } rec_t;

  // Control from the sequencer to the nearest-date tracker.
  typedef struct packed {
    logic             clr;
    logic             en;
    logic [KEY_W-1:0] key;
    logic [DAY_W-1:0] day;
  } best_ctl_t;

endpackage

// File: rtl/keyed_nearest_date_lookup.sv
// Keyed nearest-date lookup. Records live in a chain of TABLE_DEPTH cells, newest in
// the first cell. An append or a clear does not hold the input and gives no result; an
// append to a full table is dropped. A query holds the input until its result is
// loaded, whatever the fill: the chain turns once around its full length, one cell
// per cycle, while the tracker at the chain's end compares each stored record against
// the query, and a finish step then loads the result register. If an earlier result
// is still unread at that point, the load waits until it is taken.
// New transactions are accepted whenever no query is in progress, also while an
// earlier result still waits at the output.
module keyed_nearest_date_lookup
  import knd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [KEY_W-1:0]   in_key_id,
  input  logic [DAY_W-1:0]   in_day_stamp,
  input  logic [SCORE_W-1:0] in_score,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [SCORE_W-1:0] out_best_score
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [KEY_W-1:0]   q_key_r;
  logic [DAY_W-1:0]   q_day_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [SCORE_W-1:0] out_best_score_r;

  logic               accept;
  logic               shift_en;
  logic               load_new;
  logic               load_out;
  logic               in_window;
  logic               hit;
  logic [SCORE_W-1:0] best_score;
  rec_t               head_rec;
  rec_t               new_rec;
  rec_t               chain_q [TABLE_DEPTH];
  best_ctl_t          best_ctl;

  assign accept = in_valid && in_ready;

  // Valid records sit in cells 0 to cnt_r-1, so they leave the last cell in the final
  // cnt_r steps of the turn, oldest first.
  assign in_window = ({1'b0, step_r} + {1'b0, cnt_r}) >= {1'b0, DEPTH_CNT};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FN_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    load_new = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        load_new = 1'b1;
        shift_en = accept && (in_func == FN_APPEND) && (cnt_r < DEPTH_CNT);
      end
      ST_SCAN: begin
        shift_en = 1'b1;
      end
      ST_FINISH: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && (in_func == FN_APPEND) && (cnt_r < DEPTH_CNT)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (accept && (in_func == FN_CLEAR)) begin
      cnt_nxt = '0;
    end
    step_nxt = (state_r == ST_SCAN) ? step_r + 1'b1 : '0;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_func == FN_QUERY)) begin
      q_key_r <= in_key_id;
      q_day_r <= in_day_stamp;
    end
    if (load_out) begin
      out_found_r      <= hit;
      out_best_score_r <= hit ? best_score : '0;
    end
  end

  assign new_rec.key   = in_key_id;
  assign new_rec.day   = in_day_stamp;
  assign new_rec.score = in_score;
  // An append pushes into the head; a scan feeds the last cell back around.
  assign head_rec = load_new ? new_rec : chain_q[TABLE_DEPTH-1];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      knd_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .rec_in   (head_rec),
        .rec_out  (chain_q[g])
      );
    end else begin : g_body
      knd_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .rec_in   (chain_q[g-1]),
        .rec_out  (chain_q[g])
      );
    end
  end

  assign best_ctl.clr = accept && (in_func == FN_QUERY);
  assign best_ctl.en  = (state_r == ST_SCAN) && in_window;
  assign best_ctl.key = q_key_r;
  assign best_ctl.day = q_day_r;

  knd_best u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (best_ctl),
    .rec        (chain_q[TABLE_DEPTH-1]),
    .hit        (hit),
    .best_score (best_score)
  );

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_best_score = out_best_score_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("record count exceeds table depth");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == FN_QUERY)) |=> (state_r == ST_SCAN) && (step_r == '0))
    else $error("query did not start a scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (step_r == LAST_STEP)) |=> (state_r == ST_FINISH))
    else $error("scan did not end after a full turn");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish state");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("transaction accepted during a query");

endmodule

// File: rtl/knd_cell.sv
module knd_cell
  import knd_pkg::*;
(
  input  logic clk,
  input  logic shift_en,
  input  rec_t rec_in,
  output rec_t rec_out
);

  rec_t rec_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

// File: rtl/knd_best.sv
module knd_best
  import knd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  best_ctl_t          ctl,
  input  rec_t               rec,
  output logic               hit,
  output logic [SCORE_W-1:0] best_score
);

  logic               hit_r;
  logic [DAY_W-1:0]   gap_r;
  logic [SCORE_W-1:0] score_r;
  logic [DAY_W-1:0]   gap_now;
  logic               take;

  always_comb begin
    gap_now = (rec.day >= ctl.day) ? (rec.day - ctl.day) : (ctl.day - rec.day);
    // Records arrive oldest first, so taking equal distances lets the later one win.
    take = ctl.en && (rec.key == ctl.key) && (!hit_r || (gap_now <= gap_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.clr) begin
      hit_r <= 1'b0;
    end else if (take) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      gap_r   <= gap_now;
      score_r <= rec.score;
    end
  end

  assign hit        = hit_r;
  assign best_score = score_r;

endmodule
